>>> rtl/lss_pkg.sv
// Shared constants and codes for the linked sequence store.
package lss_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   localparam int CMD_W            = 3;
   localparam int POS_W            = 9;
   localparam int DATA_W           = 32;
   localparam int COUNT_W          = 9;
   localparam int STATUS_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_INSERT     = 3'd2,
      CMD_REMOVE     = 3'd3,
      CMD_POP_BACK   = 3'd4,
      CMD_POP_FRONT  = 3'd5,
      CMD_CLEAR      = 3'd6,
      CMD_READ       = 3'd7
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NOTFOUND = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

endpackage

>>> rtl/lss_req_if.sv
// Command channel of the linked sequence store.
interface lss_req_if;
   import lss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

>>> rtl/lss_rsp_if.sv
// Result channel of the linked sequence store.
interface lss_rsp_if;
   import lss_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic [COUNT_W-1:0]       element_count;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, read_value, element_count, status, input ready);
   modport sink   (input valid, read_value, element_count, status, output ready);
endinterface

>>> rtl/linked_sequence_store.sv
// Steps per item after decode: clear and early refusals go straight to the response, push
//   takes a free slot, pop reads its end slot and gives it back; positional commands walk one link
//   per cycle, at most (count-1)/2 links, so a middle insert into a long chain takes longest.
// Throughput: one item at a time; the walk is bound by the single read port of the link RAMs.
// The result register frees the input side: a new item is taken while a result waits.
// Reset: synchronous, active high; afterwards a sweep chains the free list before the first item is taken
module linked_sequence_store #(
   parameter int CAPACITY = lss_pkg::DEFAULT_CAPACITY
) (
   input logic        clock,
   input logic        reset,
   lss_req_if.sink    req_bus,
   lss_rsp_if.source  rsp_bus
);
   import lss_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IX = IDX_W'(CAPACITY - 1);

   // one-hot sequencer
   typedef enum logic [7:0] {
      S_INIT   = 8'b0000_0001,  // free list chaining sweep
      S_IDLE   = 8'b0000_0010,
      S_DECODE = 8'b0000_0100,
      S_WALK   = 8'b0000_1000,  // one link per cycle
      S_TAKE   = 8'b0001_0000,  // pop a free slot, link it
      S_LINK   = 8'b0010_0000,  // second half of a middle insert
      S_GIVE   = 8'b0100_0000,  // return a slot to the free list
      S_RESP   = 8'b1000_0000
   } state_type;

   typedef enum logic [1:0] {
      MODE_BACK  = 2'd0,
      MODE_FRONT = 2'd1,
      MODE_MID   = 2'd2
   } mode_type;

   // slot RAMs: value, next link, previous link
   logic signed [DATA_W-1:0] val_mem [CAPACITY];
   logic [IDX_W-1:0]         nxt_mem [CAPACITY];
   logic [IDX_W-1:0]         prv_mem [CAPACITY];

   logic signed [DATA_W-1:0] rd_val_ff;
   logic [IDX_W-1:0]         rd_nxt_ff, rd_prv_ff;
   logic [IDX_W-1:0]         rd_addr;

   logic                     val_we, nxt_we, prv_we;
   logic [IDX_W-1:0]         val_wa, nxt_wa, prv_wa;
   logic [IDX_W-1:0]         nxt_wd, prv_wd;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [DATA_W-1:0] data_ff;

   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [IDX_W-1:0]         free_ff, free_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         init_ff, init_in;

   logic [IDX_W-1:0]         cur_ff, cur_in;
   logic [CNT_W-1:0]         steps_ff, steps_in;
   logic                     back_ff, back_in;
   mode_type                 mode_ff, mode_in;
   logic [IDX_W-1:0]         prev_ff, prev_in;   // predecessor for a middle insert
   logic [IDX_W-1:0]         new_ff, new_in;     // slot just taken

   logic signed [DATA_W-1:0] res_val_ff, res_val_in;
   status_type               res_status_ff, res_status_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_val_ff;
   logic [COUNT_W-1:0]       rsp_cnt_ff;
   status_type               rsp_status_ff;
   logic                     out_load;

   logic                     accept;
   logic                     full, pos_ok, go_back;
   logic [CMP_W-1:0]         pos_x, cnt_x;

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign accept                = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.read_value    = rsp_val_ff;
   assign rsp_bus.element_count = rsp_cnt_ff;
   assign rsp_bus.status        = rsp_status_ff;

   assign pos_x   = CMP_W'(pos_ff);
   assign cnt_x   = CMP_W'(count_ff);
   assign full    = (count_ff == CAP_CNT);
   assign pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
   // walk from the tail when it is no farther than from the head
   assign go_back = (cnt_x - pos_x) <= (pos_x - CMP_W'(1));

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      init_in       = init_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      back_in       = back_ff;
      mode_in       = mode_ff;
      prev_in       = prev_ff;
      new_in        = new_ff;
      res_val_in    = res_val_ff;
      res_status_in = res_status_ff;
      out_load      = 1'b0;
      rd_addr       = cur_ff;
      val_we        = 1'b0;
      val_wa        = free_ff;
      nxt_we        = 1'b0;
      nxt_wa        = '0;
      nxt_wd        = '0;
      prv_we        = 1'b0;
      prv_wa        = '0;
      prv_wd        = '0;

      unique case (state_ff)
         S_INIT: begin
            nxt_we  = 1'b1;
            nxt_wa  = init_ff;
            nxt_wd  = (init_ff == LAST_IX) ? '0 : init_ff + IDX_W'(1);
            init_in = init_ff + IDX_W'(1);
            if (init_ff == LAST_IX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_val_in    = '0;
            res_status_in = STATUS_OK;
            case (cmd_ff)
               CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT: begin
                  if (full) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_RESP;
                  end else if (cmd_ff == CMD_INSERT && pos_ok && pos_ff != POS_W'(1)) begin
                     back_in  = go_back;
                     cur_in   = go_back ? tail_ff : head_ff;
                     steps_in = go_back ? CNT_W'(cnt_x - pos_x) : CNT_W'(pos_x - CMP_W'(1));
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end else begin
                     // insert at the first position goes to the front, a bad one appends
                     mode_in  = (cmd_ff == CMD_PUSH_FRONT || (cmd_ff == CMD_INSERT && pos_ok))
                                ? MODE_FRONT : MODE_BACK;
                     rd_addr  = free_ff;
                     state_in = S_TAKE;
                  end
               end
               CMD_REMOVE, CMD_READ: begin
                  if (!pos_ok) begin
                     res_status_in = STATUS_NOTFOUND;
                     state_in      = S_RESP;
                  end else begin
                     back_in  = go_back;
                     cur_in   = go_back ? tail_ff : head_ff;
                     steps_in = go_back ? CNT_W'(cnt_x - pos_x) : CNT_W'(pos_x - CMP_W'(1));
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end
               end
               CMD_POP_BACK, CMD_POP_FRONT: begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_NOTFOUND;
                     state_in      = S_RESP;
                  end else begin
                     cur_in   = (cmd_ff == CMD_POP_BACK) ? tail_ff : head_ff;
                     steps_in = '0;
                     rd_addr  = cur_in;
                     state_in = S_WALK;
                  end
               end
               default: begin  // clear: splice the whole chain onto the free list
                  if (count_ff != '0) begin
                     nxt_we   = 1'b1;
                     nxt_wa   = tail_ff;
                     nxt_wd   = free_ff;
                     free_in  = head_ff;
                     count_in = '0;
                     head_in  = '0;
                     tail_in  = '0;
                  end
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            if (steps_ff != '0) begin
               cur_in   = back_ff ? rd_prv_ff : rd_nxt_ff;
               rd_addr  = cur_in;
               steps_in = steps_ff - CNT_W'(1);
            end else begin
               // links and value of the target slot are in the read registers
               case (cmd_ff)
                  CMD_READ: begin
                     res_val_in = rd_val_ff;
                     state_in   = S_RESP;
                  end
                  CMD_INSERT: begin
                     prev_in  = rd_prv_ff;
                     mode_in  = MODE_MID;
                     rd_addr  = free_ff;
                     state_in = S_TAKE;
                  end
                  default: begin  // remove, pop back, pop front
                     if (cur_ff == head_ff) begin
                        head_in = rd_nxt_ff;
                     end else begin
                        nxt_we = 1'b1;
                        nxt_wa = rd_prv_ff;
                        nxt_wd = rd_nxt_ff;
                     end
                     if (cur_ff == tail_ff) begin
                        tail_in = rd_prv_ff;
                     end else begin
                        prv_we = 1'b1;
                        prv_wa = rd_nxt_ff;
                        prv_wd = rd_prv_ff;
                     end
                     count_in = count_ff - CNT_W'(1);
                     state_in = S_GIVE;
                  end
               endcase
            end
         end
         S_TAKE: begin
            // rd_nxt_ff holds the link after the free head
            val_we   = 1'b1;
            val_wa   = free_ff;
            free_in  = rd_nxt_ff;
            new_in   = free_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
            case (mode_ff)
               MODE_BACK: begin
                  prv_we = 1'b1;
                  prv_wa = free_ff;
                  prv_wd = tail_ff;
                  if (count_ff != '0) begin
                     nxt_we = 1'b1;
                     nxt_wa = tail_ff;
                     nxt_wd = free_ff;
                  end else begin
                     head_in = free_ff;
                  end
                  tail_in = free_ff;
               end
               MODE_FRONT: begin
                  nxt_we = 1'b1;
                  nxt_wa = free_ff;
                  nxt_wd = head_ff;
                  if (count_ff != '0) begin
                     prv_we = 1'b1;
                     prv_wa = head_ff;
                     prv_wd = free_ff;
                  end else begin
                     tail_in = free_ff;
                  end
                  head_in = free_ff;
               end
               default: begin  // between prev_ff and cur_ff
                  prv_we   = 1'b1;
                  prv_wa   = free_ff;
                  prv_wd   = prev_ff;
                  nxt_we   = 1'b1;
                  nxt_wa   = free_ff;
                  nxt_wd   = cur_ff;
                  state_in = S_LINK;
               end
            endcase
         end
         S_LINK: begin
            nxt_we   = 1'b1;
            nxt_wa   = prev_ff;
            nxt_wd   = new_ff;
            prv_we   = 1'b1;
            prv_wa   = cur_ff;
            prv_wd   = new_ff;
            state_in = S_RESP;
         end
         S_GIVE: begin
            nxt_we   = 1'b1;
            nxt_wa   = cur_ff;
            nxt_wd   = free_ff;
            free_in  = cur_ff;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         init_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= cmd_type'(req_bus.cmd);
         pos_ff  <= req_bus.position;
         data_ff <= req_bus.value;
      end
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      back_ff       <= back_in;
      mode_ff       <= mode_in;
      prev_ff       <= prev_in;
      new_ff        <= new_in;
      res_val_ff    <= res_val_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_val_ff    <= res_val_ff;
         rsp_cnt_ff    <= cnt_x[COUNT_W-1:0];
         rsp_status_ff <= res_status_ff;
      end
   end

   // slot RAMs, registered read at a shared address
   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= data_ff;
      end
      rd_val_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         nxt_mem[nxt_wa] <= nxt_wd;
      end
      rd_nxt_ff <= nxt_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (prv_we) begin
         prv_mem[prv_wa] <= prv_wd;
      end
      rd_prv_ff <= prv_mem[rd_addr];
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("element count above capacity");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECODE)
      else $error("accepted item not decoded");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside the response step");

   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_FULL) |->
         CMP_W'(rsp_cnt_ff) == CMP_W'(CAP_CNT))
      else $error("full refusal below capacity");
`endif

endmodule

>>> tb/lss_tb_if.sv
// Testbench package: the expected outcome of one item.
package lss_tb_pkg;
   import lss_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       element_count;
      status_type               status;
   } lss_outcome_type;
endpackage

>>> tb/lss_checker.sv
// Checker: predicts each result of the linked sequence store and compares it.
module lss_checker
   import lss_pkg::*;
   import lss_tb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lss_req_if.sink    req_mon,
   lss_rsp_if.sink    rsp_mon,
   output int         fail_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = DEFAULT_CAPACITY;

   // mirror of the stored sequence, front at index 0
   logic signed [DATA_W-1:0] seq_mirror[$];
   lss_outcome_type          outcome_q[$];

   function automatic lss_outcome_type apply_command(cmd_type op, int pos,
                                                     logic signed [DATA_W-1:0] val);
      lss_outcome_type o;
      int n;
      n = seq_mirror.size();
      o.read_value = '0;
      o.status     = STATUS_OK;
      case (op)
         CMD_PUSH_BACK: begin
            if (n >= CAP) o.status = STATUS_FULL; else seq_mirror.push_back(val);
         end
         CMD_PUSH_FRONT: begin
            if (n >= CAP) o.status = STATUS_FULL; else seq_mirror.push_front(val);
         end
         CMD_INSERT: begin
            if (n >= CAP) o.status = STATUS_FULL;
            else if (pos == 0 || pos > n) seq_mirror.push_back(val);
            else seq_mirror.insert(pos - 1, val);
         end
         CMD_REMOVE: begin
            if (pos == 0 || pos > n) o.status = STATUS_NOTFOUND;
            else seq_mirror.delete(pos - 1);
         end
         CMD_POP_BACK: begin
            if (n == 0) o.status = STATUS_NOTFOUND; else void'(seq_mirror.pop_back());
         end
         CMD_POP_FRONT: begin
            if (n == 0) o.status = STATUS_NOTFOUND; else void'(seq_mirror.pop_front());
         end
         CMD_CLEAR: seq_mirror.delete();
         default: begin
            if (pos == 0 || pos > n) o.status = STATUS_NOTFOUND;
            else o.read_value = seq_mirror[pos - 1];
         end
      endcase
      o.element_count = COUNT_W'(seq_mirror.size());
      return o;
   endfunction

   always @(posedge clock) begin
      lss_outcome_type exp_o;
      if (reset) begin
         seq_mirror.delete();
         outcome_q.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            outcome_q.push_back(apply_command(cmd_type'(req_mon.cmd),
                                              int'(req_mon.position), req_mon.value));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (outcome_q.size() == 0) begin
               $error("unexpected result: no item outstanding");
               fail_count++;
            end else begin
               exp_o = outcome_q.pop_front();
               if (rsp_mon.read_value !== exp_o.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         exp_o.read_value, rsp_mon.read_value);
                  fail_count++;
               end
               if (rsp_mon.element_count !== exp_o.element_count) begin
                  $error("element_count: expected %0d, got %0d",
                         exp_o.element_count, rsp_mon.element_count);
                  fail_count++;
               end
               if (rsp_mon.status !== exp_o.status) begin
                  $error("status: expected %0d, got %0d", exp_o.status, rsp_mon.status);
                  fail_count++;
               end
            end
         end
      end
      pending = outcome_q.size();
   end

   initial begin
      fail_count = 0;
      pending    = 0;
   end
endmodule

>>> tb/linked_sequence_store_tb.sv
// Top of the linked sequence store testbench: stimulus, idling and verdict.
module linked_sequence_store_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lss_pkg::*;

   localparam int CAP = DEFAULT_CAPACITY;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   shadow_count;   // element count as the stimulus sees it, for biasing

   lss_req_if req_bus ();
   lss_rsp_if rsp_bus ();

   linked_sequence_store #(.CAPACITY(CAP)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   lss_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus.sink),
      .rsp_mon    (rsp_bus.sink),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: the slowest run is roughly 2000 items, each with a walk and random idling; allow plenty.
   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

   // Result side: random back-pressure before each item, with
   // calm stretches where ready just stays high.
   initial begin
      int wait_cycles;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         rsp_bus.ready = 1'b0;
         repeat (wait_cycles) @(negedge clock);
         rsp_bus.ready = 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // One command item; the sender may idle for a random gap first. Valid stays high
   // across back-to-back items, never dropped and raised in one step.
   task automatic send_item(cmd_type op, int pos, logic signed [DATA_W-1:0] val);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.cmd      = op;
      req_bus.position = pos[POS_W-1:0];
      req_bus.value    = val;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      // track the count for biasing only; the checker owns prediction
      case (op)
         CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_INSERT:
            if (shadow_count < CAP) shadow_count++;
         CMD_REMOVE: if (pos >= 1 && pos <= shadow_count) shadow_count--;
         CMD_POP_BACK, CMD_POP_FRONT: if (shadow_count > 0) shadow_count--;
         CMD_CLEAR: shadow_count = 0;
         default: ;
      endcase
      @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   // Positions mostly in range, sometimes 0, just past the count, or far out.
   function automatic int pick_position();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return shadow_count + 1;
         2: return $urandom_range(0, 511);
         3: return (shadow_count > 0) ? shadow_count : 1;
         default: return $urandom_range(1, (shadow_count > 0) ? shadow_count : 1);
      endcase
   endfunction

   initial begin
      int       phase_len;
      int       grow_bias;
      cmd_type  op;
      req_bus.valid    = 1'b0;
      req_bus.cmd      = CMD_PUSH_BACK;
      req_bus.position = '0;
      req_bus.value    = '0;
      shadow_count     = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty-store corner cases, extremes, each command, insert at 1.
      send_item(CMD_POP_BACK, 0, '0);
      send_item(CMD_POP_FRONT, 0, '0);
      send_item(CMD_READ, 1, '0);
      send_item(CMD_REMOVE, 0, '0);
      send_item(CMD_CLEAR, 0, '0);
      send_item(CMD_PUSH_BACK, 0, 32'sh7FFF_FFFF);
      send_item(CMD_PUSH_FRONT, 511, 32'sh8000_0000);
      send_item(CMD_INSERT, 1, -1);
      send_item(CMD_INSERT, 0, 32'sh5555_5555);
      send_item(CMD_INSERT, 9, 32'shAAAA_AAAA);
      send_item(CMD_INSERT, 3, 32'sh0000_0001);
      send_item(CMD_READ, 0, '0);
      send_item(CMD_READ, 1, '0);
      send_item(CMD_READ, 6, '0);
      send_item(CMD_READ, 7, '0);
      send_item(CMD_READ, 511, '0);
      send_item(CMD_REMOVE, 3, '0);
      send_item(CMD_REMOVE, 6, '0);
      send_item(CMD_POP_BACK, 0, '0);
      send_item(CMD_POP_FRONT, 0, '0);
      send_item(CMD_CLEAR, 0, '0);
      send_item(CMD_READ, 1, '0);

      // Fill to capacity, then refused pushes and inserts, then positional hits at full and one miss.
      while (shadow_count < CAP) send_item(cmd_type'($urandom_range(0, 2)),
                                           pick_position(), pick_value());
      send_item(CMD_PUSH_BACK, 0, 32'sh1234_5678);
      send_item(CMD_PUSH_FRONT, 0, 32'sh1234_5678);
      send_item(CMD_INSERT, 5, 32'sh1234_5678);
      send_item(CMD_READ, CAP, '0);
      send_item(CMD_READ, CAP / 2, '0);
      send_item(CMD_READ, CAP / 2 + 1, '0);
      send_item(CMD_REMOVE, CAP, '0);
      send_item(CMD_READ, 256, '0);

      // Random: phases that lean toward growing or shrinking the store.
      for (int done = 0; done < 1650; done += phase_len) begin
         phase_len = $urandom_range(40, 200);
         grow_bias = $urandom_range(20, 80);
         for (int k = 0; k < phase_len; k++) begin
            if ($urandom_range(0, 99) == 0) op = CMD_CLEAR;
            else if ($urandom_range(0, 99) < grow_bias)
               op = cmd_type'($urandom_range(0, 2));
            else case ($urandom_range(0, 3))
               0: op = CMD_REMOVE;
               1: op = CMD_POP_BACK;
               2: op = CMD_POP_FRONT;
               default: op = CMD_READ;
            endcase
            // reads are cheap to add and exercise the walk
            if ($urandom_range(0, 3) == 0) op = CMD_READ;
            send_item(op, pick_position(), pick_value());
         end
      end

      req_bus.valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (CAP / 2 + 10) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

>>> filelist.f
rtl/lss_pkg.sv
rtl/lss_req_if.sv
rtl/lss_rsp_if.sv
rtl/linked_sequence_store.sv
tb/lss_tb_if.sv
tb/lss_checker.sv
tb/linked_sequence_store_tb.sv
